// ----- sv/assert_macros.svh -----
// Assertion macros shared by the trimap refine RTL.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TRP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trimap refine: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trimap refine: next-cycle check failed");

`endif

// ----- sv/trp_pkg.sv -----
// Types and constants of the trimap pixel refine block.
// No dependencies; used by trimap_pixel_refine, trp_regs, trp_chroma and trp_rules.
`default_nettype none

package trp_pkg;

    localparam int CHROMA_W = 26;   // every chroma value is positive and below 2^26
    localparam int PROD_W   = 25;
    localparam int SUM_W    = 27;
    localparam int LIMIT_W  = 9;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    typedef logic [1:0] trp_class_t;
    localparam trp_class_t CLS_BG  = 2'd0;
    localparam trp_class_t CLS_UNK = 2'd1;
    localparam trp_class_t CLS_FG  = 2'd2;
    localparam trp_class_t CLS_BAD = 2'd3;

    typedef logic [2:0] trp_reg_idx_t;
    localparam trp_reg_idx_t REG_CB_LOW        = 3'd0;
    localparam trp_reg_idx_t REG_CB_HIGH       = 3'd1;
    localparam trp_reg_idx_t REG_CR_LOW        = 3'd2;
    localparam trp_reg_idx_t REG_CR_HIGH       = 3'd3;
    localparam trp_reg_idx_t REG_LIMIT_DEMOTE  = 3'd4;
    localparam trp_reg_idx_t REG_LIMIT_PROMOTE = 3'd5;
    localparam trp_reg_idx_t REG_LIMIT_KEEP    = 3'd6;

    // chroma scaled by 255000
    localparam logic [CHROMA_W-1:0] CHROMA_SCALE = CHROMA_W'(255000);
    localparam logic [SUM_W-1:0]    CHROMA_BIAS  = SUM_W'(32640000);

    localparam logic [PROD_W-1:0] CB_R_COEF = PROD_W'(37797);
    localparam logic [PROD_W-1:0] CB_G_COEF = PROD_W'(74203);
    localparam logic [PROD_W-1:0] CB_B_COEF = PROD_W'(112000);
    localparam logic [PROD_W-1:0] CR_R_COEF = PROD_W'(112000);
    localparam logic [PROD_W-1:0] CR_G_COEF = PROD_W'(93768);
    localparam logic [PROD_W-1:0] CR_B_COEF = PROD_W'(18214);

    localparam logic [7:0] CB_LOW_RST  = 8'd115;
    localparam logic [7:0] CB_HIGH_RST = 8'd141;
    localparam logic [7:0] CR_LOW_RST  = 8'd115;
    localparam logic [7:0] CR_HIGH_RST = 8'd143;
    localparam logic [LIMIT_W-1:0] LIMIT_DEMOTE_RST  = 9'd100;
    localparam logic [LIMIT_W-1:0] LIMIT_PROMOTE_RST = 9'd60;
    localparam logic [LIMIT_W-1:0] LIMIT_KEEP_RST    = 9'd80;

    typedef struct packed {
        logic [CHROMA_W-1:0] cb_low_s;
        logic [CHROMA_W-1:0] cb_high_s;
        logic [CHROMA_W-1:0] cr_low_s;
        logic [CHROMA_W-1:0] cr_high_s;
        logic [LIMIT_W-1:0]  limit_demote;
        logic [LIMIT_W-1:0]  limit_promote;
        logic [LIMIT_W-1:0]  limit_keep;
    } trp_cfg_t;

    // test outcomes handed from the chroma pipe to the rule stage
    typedef struct packed {
        logic       matte_zero;
        trp_class_t cls;
        logic       pass_demote;
        logic       pass_promote;
        logic       pass_keep;
    } trp_flags_t;

    function automatic logic [CHROMA_W-1:0] scale_bound(input logic [7:0] b);
        scale_bound = CHROMA_W'(b) * CHROMA_SCALE;
    endfunction

endpackage

`default_nettype wire

// ----- sv/trp_pix_if.sv -----
// Pixel channel: valid/ready handshake with matte, class and RGB payload.
// Depends on nothing.
`default_nettype none

interface trp_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] matte_value;
    logic [1:0] class_in;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, matte_value, class_in, red, green, blue, input ready);
    modport sink   (input valid, matte_value, class_in, red, green, blue, output ready);
endinterface

`default_nettype wire

// ----- sv/trp_cls_if.sv -----
// Result channel: valid/ready handshake carrying the refined class.
// Depends on nothing.
`default_nettype none

interface trp_cls_if;
    logic       valid;
    logic       ready;
    logic [1:0] class_out;

    modport source (output valid, class_out, input ready);
    modport sink   (input valid, class_out, output ready);
endinterface

`default_nettype wire

// ----- sv/trimap_pixel_refine.sv -----
// Trimap pixel refine: one pixel per clock while the result side accepts. A pixel beat
// passes three chroma stages plus the rule/output register to become its class beat.
// Every stage holds its own valid bit, so a stall on the result side fills the
// empty stages before pixel.ready drops. The user must write registers through the
// APB-style port only while the pipe is empty; the block does not enforce this.
`default_nettype none

module trimap_pixel_refine
    import trp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    trp_pix_if.sink                pixel,
    trp_cls_if.source              result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    trp_cfg_t   cfg;
    trp_flags_t flags;
    logic       flags_valid;
    logic       flags_ready;

    trp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    trp_chroma u_chroma (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .cfg         (cfg),
        .flags_valid (flags_valid),
        .flags_ready (flags_ready),
        .flags       (flags)
    );

    trp_rules u_rules (
        .clk         (clk),
        .rst_n       (rst_n),
        .flags_valid (flags_valid),
        .flags_ready (flags_ready),
        .flags       (flags),
        .result      (result)
    );

endmodule

`default_nettype wire

// ----- sv/trp_regs.sv -----
// APB-style register file for the chroma bounds and red limits.
// Depends on trp_pkg; keeps bounds pre-scaled by 255000 for the compare stage.
`default_nettype none

module trp_regs
    import trp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output trp_cfg_t               cfg
);

    logic [7:0]          cb_low_reg, cb_high_reg, cr_low_reg, cr_high_reg;
    logic [CHROMA_W-1:0] cb_low_s_reg, cb_high_s_reg, cr_low_s_reg, cr_high_s_reg;
    logic [LIMIT_W-1:0]  lim_dem_reg, lim_pro_reg, lim_keep_reg;
    logic [CHROMA_W-1:0] wr_scaled;
    trp_reg_idx_t        idx;
    logic                wr_en;

    assign pready    = 1'b1;
    assign idx       = paddr[ADDR_W-1:2];
    assign wr_en     = psel & penable & pwrite;
    assign wr_scaled = scale_bound(pwdata[7:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cb_low_reg    <= CB_LOW_RST;
            cb_high_reg   <= CB_HIGH_RST;
            cr_low_reg    <= CR_LOW_RST;
            cr_high_reg   <= CR_HIGH_RST;
            cb_low_s_reg  <= scale_bound(CB_LOW_RST);
            cb_high_s_reg <= scale_bound(CB_HIGH_RST);
            cr_low_s_reg  <= scale_bound(CR_LOW_RST);
            cr_high_s_reg <= scale_bound(CR_HIGH_RST);
            lim_dem_reg   <= LIMIT_DEMOTE_RST;
            lim_pro_reg   <= LIMIT_PROMOTE_RST;
            lim_keep_reg  <= LIMIT_KEEP_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_CB_LOW:
                begin
                    cb_low_reg   <= pwdata[7:0];
                    cb_low_s_reg <= wr_scaled;
                end
                REG_CB_HIGH:
                begin
                    cb_high_reg   <= pwdata[7:0];
                    cb_high_s_reg <= wr_scaled;
                end
                REG_CR_LOW:
                begin
                    cr_low_reg   <= pwdata[7:0];
                    cr_low_s_reg <= wr_scaled;
                end
                REG_CR_HIGH:
                begin
                    cr_high_reg   <= pwdata[7:0];
                    cr_high_s_reg <= wr_scaled;
                end
                REG_LIMIT_DEMOTE:  lim_dem_reg  <= pwdata[LIMIT_W-1:0];
                REG_LIMIT_PROMOTE: lim_pro_reg  <= pwdata[LIMIT_W-1:0];
                REG_LIMIT_KEEP:    lim_keep_reg <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_CB_LOW:        prdata = DATA_W'(cb_low_reg);
            REG_CB_HIGH:       prdata = DATA_W'(cb_high_reg);
            REG_CR_LOW:        prdata = DATA_W'(cr_low_reg);
            REG_CR_HIGH:       prdata = DATA_W'(cr_high_reg);
            REG_LIMIT_DEMOTE:  prdata = DATA_W'(lim_dem_reg);
            REG_LIMIT_PROMOTE: prdata = DATA_W'(lim_pro_reg);
            REG_LIMIT_KEEP:    prdata = DATA_W'(lim_keep_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.cb_low_s      = cb_low_s_reg;
    assign cfg.cb_high_s     = cb_high_s_reg;
    assign cfg.cr_low_s      = cr_low_s_reg;
    assign cfg.cr_high_s     = cr_high_s_reg;
    assign cfg.limit_demote  = lim_dem_reg;
    assign cfg.limit_promote = lim_pro_reg;
    assign cfg.limit_keep    = lim_keep_reg;

endmodule

`default_nettype wire

// ----- sv/trp_chroma.sv -----
// Three-stage chroma pipe: constant products, chroma sums, bound compares.
// Depends on trp_pkg and trp_pix_if; hands a trp_flags_t beat to the rule stage.
`default_nettype none

module trp_chroma
    import trp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    trp_pix_if.sink       pixel,
    input  wire trp_cfg_t cfg,
    output logic          flags_valid,
    input  wire logic     flags_ready,
    output trp_flags_t    flags
);

    logic adv1, adv2, adv3;
    logic v1_reg, v2_reg, v3_reg;

    // stage 1: products
    logic [PROD_W-1:0] cb_r_reg, cb_g_reg, cb_b_reg, cr_r_reg, cr_g_reg, cr_b_reg;
    logic              mz1_reg;
    trp_class_t        cls1_reg, cls_norm;
    logic [7:0]        red1_reg;

    // stage 2: chroma values
    logic [CHROMA_W-1:0] cb2_reg, cr2_reg;
    logic [SUM_W-1:0]    cb_sum, cr_sum;
    logic                mz2_reg;
    trp_class_t          cls2_reg;
    logic [7:0]          red2_reg;

    // stage 3: test outcomes
    trp_flags_t flags_reg;
    logic       chroma_ok;
    logic [LIMIT_W-1:0] red_ext;

    assign adv3        = !v3_reg || flags_ready;
    assign adv2        = !v2_reg || adv3;
    assign adv1        = !v1_reg || adv2;
    assign pixel.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= pixel.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // class code three counts as background
    assign cls_norm = (pixel.class_in == CLS_BAD) ? CLS_BG : pixel.class_in;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            cb_r_reg <= PROD_W'(pixel.red)   * CB_R_COEF;
            cb_g_reg <= PROD_W'(pixel.green) * CB_G_COEF;
            cb_b_reg <= PROD_W'(pixel.blue)  * CB_B_COEF;
            cr_r_reg <= PROD_W'(pixel.red)   * CR_R_COEF;
            cr_g_reg <= PROD_W'(pixel.green) * CR_G_COEF;
            cr_b_reg <= PROD_W'(pixel.blue)  * CR_B_COEF;
            mz1_reg  <= (pixel.matte_value == 8'd0);
            cls1_reg <= cls_norm;
            red1_reg <= pixel.red;
        end
    end

    // both sums stay positive and below 2^26 for any 8-bit RGB
    assign cb_sum = CHROMA_BIAS + SUM_W'(cb_b_reg) - SUM_W'(cb_r_reg) - SUM_W'(cb_g_reg);
    assign cr_sum = CHROMA_BIAS + SUM_W'(cr_r_reg) - SUM_W'(cr_g_reg) - SUM_W'(cr_b_reg);

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            cb2_reg  <= cb_sum[CHROMA_W-1:0];
            cr2_reg  <= cr_sum[CHROMA_W-1:0];
            mz2_reg  <= mz1_reg;
            cls2_reg <= cls1_reg;
            red2_reg <= red1_reg;
        end
    end

    assign chroma_ok = (cb2_reg >= cfg.cb_low_s) && (cb2_reg <= cfg.cb_high_s) &&
                       (cr2_reg >= cfg.cr_low_s) && (cr2_reg <= cfg.cr_high_s);
    assign red_ext   = LIMIT_W'(red2_reg);

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            flags_reg.matte_zero   <= mz2_reg;
            flags_reg.cls          <= cls2_reg;
            flags_reg.pass_demote  <= chroma_ok && (red_ext < cfg.limit_demote);
            flags_reg.pass_promote <= chroma_ok && (red_ext < cfg.limit_promote);
            flags_reg.pass_keep    <= chroma_ok && (red_ext < cfg.limit_keep);
        end
    end

    assign flags_valid = v3_reg;
    assign flags       = flags_reg;

endmodule

`default_nettype wire

// ----- sv/trp_rules.sv -----
// Rule stage: applies the three ordered class rules into the output register.
// Depends on trp_pkg, trp_cls_if and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module trp_rules
    import trp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       flags_valid,
    output logic            flags_ready,
    input  wire trp_flags_t flags,
    trp_cls_if.source       result
);

    logic       out_valid_reg;
    trp_class_t cls_reg, cls_next;
    logic       load;

    assign flags_ready = !out_valid_reg || result.ready;
    assign load        = flags_valid && flags_ready;

    // each rule sees the class the previous one left
    always_comb
    begin
        cls_next = flags.cls;
        if (flags.matte_zero && cls_next == CLS_FG && flags.pass_demote)
            cls_next = CLS_UNK;
        if (cls_next == CLS_UNK && flags.pass_promote)
            cls_next = CLS_FG;
        if (flags.matte_zero && cls_next == CLS_UNK && !flags.pass_keep)
            cls_next = CLS_BG;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (flags_ready)
            out_valid_reg <= flags_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cls_reg <= cls_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.class_out = cls_reg;

    `TRP_ASSERT_SAME(a_no_bad_class, result.valid, result.class_out != CLS_BAD)
    `TRP_ASSERT_NEXT(a_bg_stays, load && flags.cls == CLS_BG, result.class_out == CLS_BG)
    `TRP_ASSERT_NEXT(a_fg_kept_nonzero_matte, load && flags.cls == CLS_FG && !flags.matte_zero,
                     result.class_out == CLS_FG)
    `TRP_ASSERT_NEXT(a_stall_holds, result.valid && !result.ready,
                     result.valid && $stable(result.class_out))

endmodule

`default_nettype wire
